>>> rtl/core/lst_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the label statistics table
// no dependencies

package lst_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned VOXEL_W  = 24;
  localparam int unsigned LCOUNT_W = 9;

  localparam logic signed [DATA_W-1:0] ATTR_MOST_POS = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] ATTR_MOST_NEG = 32'sh8000_0000;

  typedef enum logic [0:0] {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    REG_USE_ATTR = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_e;

  // one transaction as it moves down the row of cells
  typedef struct packed {
    logic                      valid;
    opcode_e                   opcode;
    logic signed [DATA_W-1:0]  label;
    logic signed [DATA_W-1:0]  attribute;
    logic [ID_W-1:0]           read_id;
    logic                      done;
    logic [ID_W-1:0]           id;
    logic                      is_new;
    logic                      rd_valid;
    logic signed [DATA_W-1:0]  rd_label;
    logic [VOXEL_W-1:0]        rd_voxels;
    logic signed [DATA_W-1:0]  rd_min;
    logic signed [DATA_W-1:0]  rd_max;
  } item_t;

endpackage

>>> rtl/core/lst_cell.sv
`timescale 1ns / 1ps
// one table cell: holds the statistics of one dense id and one transaction stage
// depends on lst_pkg

module lst_cell #(
  parameter int unsigned CELL_IDX   = 0,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          use_attr_i,
  input  lst_pkg::item_t item_i,
  output lst_pkg::item_t item_o,
  output logic          entry_vld_o
);
  import lst_pkg::*;

  localparam bit             IN_RANGE = (CELL_IDX < (1 << ID_W));
  localparam logic [ID_W-1:0] CELL_ID = ID_W'(CELL_IDX);

  logic                      vld_q;
  logic signed [DATA_W-1:0]  label_q;
  logic [COUNT_BITS-1:0]     count_q;
  logic signed [DATA_W-1:0]  min_q;
  logic signed [DATA_W-1:0]  max_q;
  item_t                     item_q;
  item_t                     item_d;

  logic                      acc;
  logic                      hit;
  logic                      claim;
  logic                      upd;
  logic                      rd;
  logic [COUNT_BITS-1:0]     base_cnt;
  logic [COUNT_BITS-1:0]     cnt_d;
  logic signed [DATA_W-1:0]  base_min;
  logic signed [DATA_W-1:0]  base_max;
  logic signed [DATA_W-1:0]  min_d;
  logic signed [DATA_W-1:0]  max_d;
  logic [COUNT_BITS+VOXEL_W-1:0] cnt_wide;
  logic [VOXEL_W-1:0]        cnt_sat;

  always_comb begin
    acc   = item_i.valid && (item_i.opcode == OP_ACCUM) && !item_i.done;
    hit   = acc && vld_q && (item_i.label == label_q);
    claim = acc && !vld_q;
    upd   = hit || claim;
    rd    = item_i.valid && (item_i.opcode == OP_READ) && vld_q && IN_RANGE &&
            (item_i.read_id == CELL_ID);

    base_cnt = claim ? '0 : count_q;
    cnt_d    = (&base_cnt) ? base_cnt : base_cnt + 1'b1;
    base_min = claim ? ATTR_MOST_POS : min_q;
    base_max = claim ? ATTR_MOST_NEG : max_q;
    min_d    = (use_attr_i && ($signed(item_i.attribute) < $signed(base_min))) ?
               item_i.attribute : base_min;
    max_d    = (use_attr_i && ($signed(item_i.attribute) > $signed(base_max))) ?
               item_i.attribute : base_max;

    // clip the stored count to the voxel field
    cnt_wide = (COUNT_BITS+VOXEL_W)'(count_q);
    cnt_sat  = (|cnt_wide[COUNT_BITS+VOXEL_W-1:VOXEL_W]) ? '1 : cnt_wide[VOXEL_W-1:0];

    item_d = item_i;
    if (upd) begin
      item_d.done   = 1'b1;
      item_d.id     = CELL_ID;
      item_d.is_new = claim;
    end
    if (rd) begin
      item_d.rd_valid  = 1'b1;
      item_d.rd_label  = label_q;
      item_d.rd_voxels = cnt_sat;
      item_d.rd_min    = min_q;
      item_d.rd_max    = max_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      item_q <= '0;
    end else if (adv_i) begin
      item_q <= item_d;
      if (claim) begin
        vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && upd) begin
      label_q <= item_i.label;
      count_q <= cnt_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

  assign item_o      = item_q;
  assign entry_vld_o = vld_q;

endmodule

>>> rtl/core/label_statistics_table.sv
`timescale 1ns / 1ps
// label statistics table: top level, row of lst_cell stages and apb register
// depends on lst_pkg and lst_cell
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------------
//  in      | in_valid_i / in_ready_o   | opcode, label, attribute, read_id
//  out     | out_valid_o / out_ready_i | assigned_id .. entry_max (one per input)
//  cfg     | psel/penable/pwrite       | attribute tracking enable at byte address 0
//
// a transaction walks the row one cell per cycle and one transaction is accepted per cycle,
// both while the result side keeps up
// each cell compares against its own entry; first free cell takes a new label
// a stalled result freezes the whole row, so in_ready_o follows the output side
// reset clears the cell valid bits and the label counter, no clearing pass

module label_statistics_table #(
  parameter int unsigned MAX_LABELS = 256,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [0:0]                       opcode_i,
  input  logic signed [lst_pkg::DATA_W-1:0] label_i,
  input  logic signed [lst_pkg::DATA_W-1:0] attribute_i,
  input  logic [lst_pkg::ID_W-1:0]         read_id_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lst_pkg::ID_W-1:0]         assigned_id_o,
  output logic                             is_new_label_o,
  output logic                             table_full_o,
  output logic [lst_pkg::LCOUNT_W-1:0]     label_count_o,
  output logic                             entry_valid_o,
  output logic signed [lst_pkg::DATA_W-1:0] entry_label_o,
  output logic [lst_pkg::VOXEL_W-1:0]      entry_voxels_o,
  output logic signed [lst_pkg::DATA_W-1:0] entry_min_o,
  output logic signed [lst_pkg::DATA_W-1:0] entry_max_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import lst_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LABELS + 1);
  localparam int unsigned OW = (CW > LCOUNT_W) ? CW : LCOUNT_W;

  item_t                 chain [MAX_LABELS+1];
  logic [MAX_LABELS-1:0] entry_vld;
  item_t                 tail;
  logic                  adv;
  logic                  use_attr_q;
  logic [CW-1:0]         cnt_q;
  logic [CW-1:0]         cnt_now;
  logic [OW-1:0]         cnt_ext;
  reg_idx_e              reg_idx;

  assign adv        = !chain[MAX_LABELS].valid || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = in_valid_i;
    chain[0].opcode    = opcode_e'(opcode_i);
    chain[0].label     = label_i;
    chain[0].attribute = attribute_i;
    chain[0].read_id   = read_id_i;
  end

  for (genvar g = 0; g < MAX_LABELS; g++) begin : g_cell
    lst_cell #(
      .CELL_IDX  (g),
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .use_attr_i (use_attr_q),
      .item_i     (chain[g]),
      .item_o     (chain[g+1]),
      .entry_vld_o(entry_vld[g])
    );
  end

  assign tail = chain[MAX_LABELS];

  // labels entered by transactions that have already left the row
  assign cnt_now = cnt_q + CW'(tail.valid && tail.is_new);
  assign cnt_ext = OW'(cnt_now);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (tail.valid && out_ready_i) begin
      cnt_q <= cnt_now;
    end
  end

  assign out_valid_o    = tail.valid;
  assign assigned_id_o  = tail.id;
  assign is_new_label_o = tail.is_new;
  assign table_full_o   = (tail.opcode == OP_ACCUM) && !tail.done;
  assign label_count_o  = cnt_ext[LCOUNT_W-1:0];
  assign entry_valid_o  = tail.rd_valid;
  assign entry_label_o  = tail.rd_label;
  assign entry_voxels_o = tail.rd_voxels;
  assign entry_min_o    = tail.rd_min;
  assign entry_max_o    = tail.rd_max;

  // apb register
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_attr_q <= 1'b0;
    end else if (psel && penable && pwrite && (reg_idx == REG_USE_ATTR)) begin
      use_attr_q <= pwdata[0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_USE_ATTR: prdata = {31'd0, use_attr_q};
      default:      prdata = '0;
    endcase
  end

  // checks
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_LABELS))
    else $error("label counter beyond table size");

  a_vld_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((entry_vld + 1'b1) & entry_vld) == '0)
    else $error("occupied cells not a contiguous prefix");

  a_cnt_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(entry_vld) >= cnt_now)
    else $error("label counter ahead of occupied cells");

  a_full_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail.valid && table_full_o) |-> (!tail.is_new && (tail.id == '0)))
    else $error("dropped label carries an id");

  a_read_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail.valid && tail.rd_valid) |->
      (LCOUNT_W'(tail.read_id) < label_count_o))
    else $error("read hit beyond label count");

endmodule
